// File: rtl/h2fp_pkg.sv
// ----------------------------------------------------------------------------
// h2fp_pkg
// Shared types, event codes, parse phases and helpers of the frame parser.
// ----------------------------------------------------------------------------
package h2fp_pkg;

  // Event codes
  localparam logic [3:0] EV_HEADER   = 4'd0;
  localparam logic [3:0] EV_CONTENT  = 4'd1;
  localparam logic [3:0] EV_PRIORITY = 4'd2;
  localparam logic [3:0] EV_SETTING  = 4'd3;
  localparam logic [3:0] EV_RST      = 4'd4;
  localparam logic [3:0] EV_WINDOW   = 4'd5;
  localparam logic [3:0] EV_PING     = 4'd6;
  localparam logic [3:0] EV_GA_LAST  = 4'd7;
  localparam logic [3:0] EV_GA_CODE  = 4'd8;
  localparam logic [3:0] EV_PROMISED = 4'd9;
  localparam logic [3:0] EV_END      = 4'd10;
  localparam logic [3:0] EV_SIZE_ERR = 4'd11;

  // Parse phases
  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_PADLEN  = 3'd1;
  localparam logic [2:0] PH_PRIO    = 3'd2;
  localparam logic [2:0] PH_BODY    = 3'd3;
  localparam logic [2:0] PH_PAD     = 3'd4;
  localparam logic [2:0] PH_SKIP    = 3'd5;
  localparam logic [2:0] PH_ERRSKIP = 3'd6;

  // Frame types
  localparam logic [7:0] FT_DATA     = 8'd0;
  localparam logic [7:0] FT_HEADERS  = 8'd1;
  localparam logic [7:0] FT_PRIORITY = 8'd2;
  localparam logic [7:0] FT_RST      = 8'd3;
  localparam logic [7:0] FT_SETTINGS = 8'd4;
  localparam logic [7:0] FT_PUSH     = 8'd5;
  localparam logic [7:0] FT_PING     = 8'd6;
  localparam logic [7:0] FT_GOAWAY   = 8'd7;
  localparam logic [7:0] FT_WINDOW   = 8'd8;
  localparam logic [7:0] FT_LAST     = 8'd9;

  // Flag bits
  localparam int FLAG_ACK_BIT    = 0;
  localparam int FLAG_PADDED_BIT = 3;
  localparam int FLAG_PRIO_BIT   = 5;

  // Frame header values carried with each result
  typedef struct packed {
    logic [7:0]  frame_type;
    logic [7:0]  frame_flags;
    logic [30:0] frame_stream;
    logic [23:0] payload_length;
  } hdr_t;

  // One event with its payload fields
  typedef struct packed {
    logic [3:0]  code;
    logic [7:0]  content;
    logic [30:0] dep;
    logic        excl;
    logic [7:0]  weight;
    logic [15:0] sid;
    logic [63:0] word;
  } evt_t;

  // Up to two events caused by one byte; the second never carries payload
  typedef struct packed {
    logic       a_valid;
    evt_t       a;
    logic       b_valid;
    logic [3:0] b_code;
    hdr_t       hdr;
  } step_t;

  // Remainder modulo 6 of a value below 384, by constant long division
  function automatic logic [2:0] mod6(input logic [8:0] v);
    logic [8:0] r;
    r = v;
    for (int k = 5; k >= 0; k--) begin
      if (r >= (9'd6 << k)) r = r - (9'd6 << k);
    end
    return r[2:0];
  endfunction

  // Phase of the payload byte at position pos
  function automatic logic [2:0] classify(input logic [23:0] pos, input logic pad_field,
                                          input logic [2:0] prefix_end,
                                          input logic [23:0] len, input logic [7:0] pad);
    if (pad_field && pos == 24'd0) return PH_PADLEN;
    if (pos < {21'd0, prefix_end}) return PH_PRIO;
    if ((len - pos) <= {16'd0, pad}) return PH_PAD;
    return PH_BODY;
  endfunction

endpackage

// File: rtl/http2_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// http2_frame_parser_unit
// HTTP/2 frame header and payload parser, one stream byte per input beat.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with data_byte, one frame byte per beat.
// Output channel: out_valid / out_stall with one event per beat; the events
// of one byte come out in order and the last one has last_of_step set.
// A byte is decoded in the cycle it is accepted and its events sit in the
// result register on the next cycle.
// Throughput is one byte per cycle while each byte gives at most one event
// and the receiver does not stall; a byte that gives two (header with size
// error or empty payload, or a last payload byte with an event and a frame
// end) holds the input until the first of them is taken from the register.
// When the receiver stalls, the result register holds its beat and in_stall
// rises; bytes that give no event are still taken while a beat waits only if
// the register is free this cycle.
// Synchronous reset returns to the start of a frame header with no events
// pending.
// ----------------------------------------------------------------------------
module http2_frame_parser_unit import h2fp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  event_res,
  output logic [7:0]  frame_type,
  output logic [7:0]  frame_flags,
  output logic [30:0] frame_stream,
  output logic [23:0] payload_length,
  output logic [7:0]  content_byte,
  output logic [30:0] dependency_stream,
  output logic        exclusive_bit,
  output logic [7:0]  priority_weight,
  output logic [15:0] setting_identifier,
  output logic [63:0] word_value,
  output logic        last_of_step
);

  step_t step;
  logic  busy;
  logic  accept;

  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  h2fp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .step      (step)
  );

  h2fp_out u_out (
    .clk                (clk),
    .rst                (rst),
    .load               (accept),
    .step               (step),
    .busy               (busy),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .event_res          (event_res),
    .frame_type         (frame_type),
    .frame_flags        (frame_flags),
    .frame_stream       (frame_stream),
    .payload_length     (payload_length),
    .content_byte       (content_byte),
    .dependency_stream  (dependency_stream),
    .exclusive_bit      (exclusive_bit),
    .priority_weight    (priority_weight),
    .setting_identifier (setting_identifier),
    .word_value         (word_value),
    .last_of_step       (last_of_step)
  );

endmodule

// File: rtl/h2fp_parser.sv
// ----------------------------------------------------------------------------
// h2fp_parser
// Frame state registers and the per-byte decode that yields up to two events.
// ----------------------------------------------------------------------------
module h2fp_parser import h2fp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  data_byte,
  output step_t       step
);

  logic [2:0]  phase, phase_next;
  logic [23:0] pos, pos_next;
  logic [7:0]  ctype, ctype_next;
  logic [7:0]  cflags, cflags_next;
  logic [30:0] cstream, cstream_next;
  logic [23:0] clen, clen_next;
  logic [7:0]  pad, pad_next;
  logic [63:0] acc, acc_next;
  logic [15:0] held, held_next;
  logic [2:0]  len_mod6, len_mod6_next;
  logic [2:0]  set_mod6, set_mod6_next;

  logic        pad_field, prio_f, fault, ok;
  logic [2:0]  prefix_end;
  logic [3:0]  min_len;
  logic [63:0] acc_sh;
  logic [23:0] body_off;
  logic [24:0] pos_inc;
  evt_t        ev_a;

  // Frame layout from the header values
  always_comb begin
    pad_field  = cflags[FLAG_PADDED_BIT] &&
                 (ctype == FT_DATA || ctype == FT_HEADERS || ctype == FT_PUSH);
    prio_f     = (ctype == FT_HEADERS && cflags[FLAG_PRIO_BIT]) || ctype == FT_PRIORITY;
    prefix_end = {2'b00, pad_field} + (prio_f ? 3'd5 : 3'd0);
    min_len    = {1'b0, prefix_end} + ((ctype == FT_PUSH) ? 4'd4 : 4'd0)
                 + ((ctype == FT_GOAWAY) ? 4'd8 : 4'd0);
    acc_sh     = {acc[55:0], data_byte};
    body_off   = pos - {21'd0, prefix_end};
    pos_inc    = {1'b0, pos} + 25'd1;
  end

  // Size rules checked when the header completes
  always_comb begin
    fault = 1'b0;
    unique case (ctype)
      FT_PRIORITY: fault = (clen != 24'd5);
      FT_RST, FT_WINDOW: fault = (clen != 24'd4);
      FT_PING: fault = (clen != 24'd8);
      FT_SETTINGS: fault = (len_mod6 != 3'd0) || (cflags[FLAG_ACK_BIT] && clen != 24'd0);
      default: fault = 1'b0;
    endcase
    if (ctype <= FT_LAST && {20'd0, min_len} > clen) fault = 1'b1;
  end

  // Per-byte decode
  always_comb begin
    phase_next    = phase;
    pos_next      = pos;
    ctype_next    = ctype;
    cflags_next   = cflags;
    cstream_next  = cstream;
    clen_next     = clen;
    pad_next      = pad;
    acc_next      = acc;
    held_next     = held;
    len_mod6_next = len_mod6;
    set_mod6_next = set_mod6;
    ok            = 1'b1;
    ev_a          = '0;
    step.a_valid  = 1'b0;
    step.b_valid  = 1'b0;
    step.b_code   = EV_END;

    if (phase == PH_HEADER) begin
      // Header bytes
      if (pos == 24'd0) begin
        clen_next     = {16'd0, data_byte};
        len_mod6_next = mod6({1'b0, data_byte});
      end else if (pos < 24'd3) begin
        clen_next     = {clen[15:0], data_byte};
        len_mod6_next = mod6({4'd0, len_mod6, 2'b00} + {1'b0, data_byte});
      end else if (pos == 24'd3) begin
        ctype_next = data_byte;
      end else if (pos == 24'd4) begin
        cflags_next = data_byte;
      end else begin
        acc_next = acc_sh;
      end
      if (pos < 24'd8) begin
        pos_next = pos + 24'd1;
      end else begin
        cstream_next  = acc_sh[30:0];
        acc_next      = '0;
        pad_next      = '0;
        pos_next      = '0;
        set_mod6_next = '0;
        step.a_valid  = 1'b1;
        ev_a.code     = EV_HEADER;
        if (fault) begin
          step.b_valid = 1'b1;
          step.b_code  = EV_SIZE_ERR;
          phase_next   = (clen != 24'd0) ? PH_ERRSKIP : PH_HEADER;
        end else if (clen == 24'd0) begin
          step.b_valid = 1'b1;
          step.b_code  = EV_END;
          phase_next   = PH_HEADER;
        end else if (ctype > FT_LAST) begin
          phase_next = PH_SKIP;
        end else begin
          phase_next = classify(24'd0, pad_field, prefix_end, clen, 8'd0);
        end
      end
    end else begin
      // Payload bytes
      unique case (phase)
        PH_PADLEN: begin
          pad_next = data_byte;
          if ({16'd0, data_byte} > clen - {20'd0, min_len}) begin
            step.a_valid = 1'b1;
            ev_a.code    = EV_SIZE_ERR;
            ok           = 1'b0;
          end
        end
        PH_PRIO: begin
          acc_next = acc_sh;
          if (pos - {23'd0, pad_field} == 24'd4) begin
            step.a_valid = 1'b1;
            ev_a.code    = EV_PRIORITY;
            ev_a.dep     = acc_sh[38:8];
            ev_a.excl    = acc_sh[39];
            ev_a.weight  = acc_sh[7:0];
          end
        end
        PH_BODY: begin
          acc_next = acc_sh;
          case (ctype)
            FT_RST: begin
              if (body_off == 24'd3) begin
                step.a_valid = 1'b1;
                ev_a.code    = EV_RST;
                ev_a.word    = {32'd0, acc_sh[31:0]};
              end
            end
            FT_SETTINGS: begin
              if (set_mod6 == 3'd1) held_next = acc_sh[15:0];
              if (set_mod6 == 3'd5) begin
                step.a_valid = 1'b1;
                ev_a.code    = EV_SETTING;
                ev_a.sid     = held;
                ev_a.word    = {32'd0, acc_sh[31:0]};
              end
              set_mod6_next = (set_mod6 == 3'd5) ? 3'd0 : set_mod6 + 3'd1;
            end
            FT_PUSH: begin
              if (body_off == 24'd3) begin
                step.a_valid = 1'b1;
                ev_a.code    = EV_PROMISED;
                ev_a.word    = {33'd0, acc_sh[30:0]};
              end else if (body_off > 24'd3) begin
                step.a_valid = 1'b1;
                ev_a.code    = EV_CONTENT;
                ev_a.content = data_byte;
              end
            end
            FT_PING: begin
              if (body_off == 24'd7) begin
                step.a_valid = 1'b1;
                ev_a.code    = EV_PING;
                ev_a.word    = acc_sh;
              end
            end
            FT_GOAWAY: begin
              if (body_off == 24'd3) begin
                step.a_valid = 1'b1;
                ev_a.code    = EV_GA_LAST;
                ev_a.word    = {33'd0, acc_sh[30:0]};
              end else if (body_off == 24'd7) begin
                step.a_valid = 1'b1;
                ev_a.code    = EV_GA_CODE;
                ev_a.word    = {32'd0, acc_sh[31:0]};
              end else if (body_off > 24'd7) begin
                step.a_valid = 1'b1;
                ev_a.code    = EV_CONTENT;
                ev_a.content = data_byte;
              end
            end
            FT_WINDOW: begin
              if (body_off == 24'd3) begin
                step.a_valid = 1'b1;
                ev_a.code    = EV_WINDOW;
                ev_a.word    = {33'd0, acc_sh[30:0]};
              end
            end
            default: begin
              step.a_valid = 1'b1;
              ev_a.code    = EV_CONTENT;
              ev_a.content = data_byte;
            end
          endcase
        end
        PH_ERRSKIP: ok = 1'b0;
        default: ;
      endcase

      // Frame end or advance
      if (pos_inc >= {1'b0, clen}) begin
        if (ok) begin
          step.b_valid = 1'b1;
          step.b_code  = EV_END;
        end
        phase_next = PH_HEADER;
        pos_next   = '0;
      end else begin
        pos_next = pos_inc[23:0];
        if (!ok) phase_next = PH_ERRSKIP;
        else if (phase != PH_SKIP)
          phase_next = classify(pos_inc[23:0], pad_field, prefix_end, clen, pad_next);
      end
    end

    step.a                  = ev_a;
    step.hdr.frame_type     = ctype_next;
    step.hdr.frame_flags    = cflags_next;
    step.hdr.frame_stream   = cstream_next;
    step.hdr.payload_length = clen_next;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HEADER;
      pos      <= '0;
      ctype    <= '0;
      cflags   <= '0;
      cstream  <= '0;
      clen     <= '0;
      pad      <= '0;
      acc      <= '0;
      held     <= '0;
      len_mod6 <= '0;
      set_mod6 <= '0;
    end else if (accept) begin
      phase    <= phase_next;
      pos      <= pos_next;
      ctype    <= ctype_next;
      cflags   <= cflags_next;
      cstream  <= cstream_next;
      clen     <= clen_next;
      pad      <= pad_next;
      acc      <= acc_next;
      held     <= held_next;
      len_mod6 <= len_mod6_next;
      set_mod6 <= set_mod6_next;
    end
  end

endmodule

// File: rtl/h2fp_out.sv
// ----------------------------------------------------------------------------
// h2fp_out
// Result register holding the events of one byte and handing them out in order.
// ----------------------------------------------------------------------------
module h2fp_out import h2fp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  step_t       step,
  output logic        busy,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [3:0]  event_res,
  output logic [7:0]  frame_type,
  output logic [7:0]  frame_flags,
  output logic [30:0] frame_stream,
  output logic [23:0] payload_length,
  output logic [7:0]  content_byte,
  output logic [30:0] dependency_stream,
  output logic        exclusive_bit,
  output logic [7:0]  priority_weight,
  output logic [15:0] setting_identifier,
  output logic [63:0] word_value,
  output logic        last_of_step
);

  logic       a_valid, b_valid;
  evt_t       ev_a;
  logic [3:0] b_code;
  hdr_t       hdr;
  logic       pop;

  assign pop       = out_valid && !out_stall;
  // Upstream may load only when the register empties this cycle
  assign busy      = (a_valid && b_valid) || (out_valid && out_stall);
  assign out_valid = a_valid || b_valid;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else if (load) begin
      a_valid <= step.a_valid;
      b_valid <= step.b_valid;
    end else if (pop) begin
      if (a_valid) a_valid <= 1'b0;
      else b_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      ev_a   <= step.a;
      b_code <= step.b_code;
      hdr    <= step.hdr;
    end
  end

  // Beat fields: first event, then the trailing one with empty payload
  always_comb begin
    frame_type         = hdr.frame_type;
    frame_flags        = hdr.frame_flags;
    frame_stream       = hdr.frame_stream;
    payload_length     = hdr.payload_length;
    event_res          = a_valid ? ev_a.code : b_code;
    content_byte       = a_valid ? ev_a.content : 8'd0;
    dependency_stream  = a_valid ? ev_a.dep : 31'd0;
    exclusive_bit      = a_valid ? ev_a.excl : 1'b0;
    priority_weight    = a_valid ? ev_a.weight : 8'd0;
    setting_identifier = a_valid ? ev_a.sid : 16'd0;
    word_value         = a_valid ? ev_a.word : 64'd0;
    last_of_step       = a_valid ? !b_valid : 1'b1;
  end

  a_pop_order: assert property (@(posedge clk) disable iff (rst)
    (pop && a_valid && b_valid) |=> (!a_valid && b_valid))
    else $error("second event lost or first repeated");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> !(a_valid && b_valid) && !(out_valid && out_stall))
    else $error("result register overwritten while occupied");

  a_trailing_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !a_valid) |-> last_of_step)
    else $error("trailing event not marked last");

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Frame parser check: directed and random HTTP/2 byte streams are fed one
// byte per beat, a local frame-walk predictor builds the expected events and
// the monitor compares every event beat field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import h2fp_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  event_res;
  logic [7:0]  frame_type;
  logic [7:0]  frame_flags;
  logic [30:0] frame_stream;
  logic [23:0] payload_length;
  logic [7:0]  content_byte;
  logic [30:0] dependency_stream;
  logic        exclusive_bit;
  logic [7:0]  priority_weight;
  logic [15:0] setting_identifier;
  logic [63:0] word_value;
  logic        last_of_step;

  typedef struct packed {
    logic [3:0]  code;
    logic [7:0]  ftype;
    logic [7:0]  flags;
    logic [30:0] sid;
    logic [23:0] len;
    logic [7:0]  content;
    logic [30:0] dep;
    logic        excl;
    logic [7:0]  weight;
    logic [15:0] set_id;
    logic [63:0] word;
    logic        last;
  } frame_event_t;

  logic [7:0]   byte_queue[$];
  frame_event_t event_queue[$];
  int           errors;
  logic         quiet_in;
  logic         quiet_out;

  // Predictor state
  logic [2:0]  p_phase;
  logic [23:0] p_pos;
  logic [7:0]  p_type;
  logic [7:0]  p_flags;
  logic [30:0] p_sid;
  logic [23:0] p_len;
  logic [7:0]  p_pad;
  logic [63:0] p_acc;
  logic [15:0] p_setid;
  int          step_count;

  http2_frame_parser_unit DUT (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic has_pad_field();
    return p_flags[FLAG_PADDED_BIT] &&
           (p_type == FT_DATA || p_type == FT_HEADERS || p_type == FT_PUSH);
  endfunction

  function automatic int prefix_len();
    int p;
    p = has_pad_field();
    if ((p_type == FT_HEADERS && p_flags[FLAG_PRIO_BIT]) || p_type == FT_PRIORITY) p += 5;
    return p;
  endfunction

  function automatic int fixed_len();
    int p;
    p = prefix_len();
    if (p_type == FT_PUSH) p += 4;
    if (p_type == FT_GOAWAY) p += 8;
    return p;
  endfunction

  function automatic logic [2:0] phase_at(int pos);
    if (has_pad_field() && pos == 0) return PH_PADLEN;
    if (pos < prefix_len()) return PH_PRIO;
    if (int'(p_len) - pos <= int'(p_pad)) return PH_PAD;
    return PH_BODY;
  endfunction

  function automatic logic header_bad();
    case (p_type)
      FT_PRIORITY: if (p_len != 5) return 1'b1;
      FT_RST, FT_WINDOW: if (p_len != 4) return 1'b1;
      FT_PING: if (p_len != 8) return 1'b1;
      FT_SETTINGS: begin
        if (p_len % 6 != 0) return 1'b1;
        if (p_flags[FLAG_ACK_BIT] && p_len != 0) return 1'b1;
      end
      default: ;
    endcase
    return p_type <= FT_LAST && fixed_len() > int'(p_len);
  endfunction

  task automatic push_event(logic [3:0] code, logic [7:0] cb, logic [30:0] dep,
                            logic excl, logic [7:0] wt, logic [15:0] sid,
                            logic [63:0] word);
    frame_event_t e;
    e = '{code, p_type, p_flags, p_sid, p_len, cb, dep, excl, wt, sid, word, 1'b0};
    event_queue = {event_queue, e};
    step_count++;
  endtask

  task automatic payload_event(logic [7:0] b, int o);
    p_acc = {p_acc[55:0], b};
    case (p_type)
      FT_RST: if (o == 3) push_event(EV_RST, 0, 0, 0, 0, 0, {32'd0, p_acc[31:0]});
      FT_SETTINGS: begin
        if (o % 6 == 1) p_setid = p_acc[15:0];
        if (o % 6 == 5) push_event(EV_SETTING, 0, 0, 0, 0, p_setid, {32'd0, p_acc[31:0]});
      end
      FT_PUSH: begin
        if (o == 3) push_event(EV_PROMISED, 0, 0, 0, 0, 0, {33'd0, p_acc[30:0]});
        else if (o > 3) push_event(EV_CONTENT, b, 0, 0, 0, 0, 0);
      end
      FT_PING: if (o == 7) push_event(EV_PING, 0, 0, 0, 0, 0, p_acc);
      FT_GOAWAY: begin
        if (o == 3) push_event(EV_GA_LAST, 0, 0, 0, 0, 0, {33'd0, p_acc[30:0]});
        else if (o == 7) push_event(EV_GA_CODE, 0, 0, 0, 0, 0, {32'd0, p_acc[31:0]});
        else if (o > 7) push_event(EV_CONTENT, b, 0, 0, 0, 0, 0);
      end
      FT_WINDOW: if (o == 3) push_event(EV_WINDOW, 0, 0, 0, 0, 0, {33'd0, p_acc[30:0]});
      default: push_event(EV_CONTENT, b, 0, 0, 0, 0, 0);
    endcase
  endtask

  // Expected events of one accepted byte
  task automatic predict_byte(logic [7:0] b);
    int   pos;
    logic ok;
    step_count = 0;
    if (p_phase == PH_HEADER) begin
      if (p_pos == 0) p_len = 0;
      if (p_pos < 3) p_len = {p_len[15:0], b};
      else if (p_pos == 3) p_type = b;
      else if (p_pos == 4) p_flags = b;
      else p_acc = {p_acc[55:0], b};
      if (p_pos < 8) begin
        p_pos++;
      end else begin
        p_sid = p_acc[30:0];
        p_acc = 0;
        p_pad = 0;
        p_pos = 0;
        push_event(EV_HEADER, 0, 0, 0, 0, 0, 0);
        if (header_bad()) begin
          push_event(EV_SIZE_ERR, 0, 0, 0, 0, 0, 0);
          p_phase = (p_len != 0) ? PH_ERRSKIP : PH_HEADER;
        end else if (p_len == 0) begin
          push_event(EV_END, 0, 0, 0, 0, 0, 0);
          p_phase = PH_HEADER;
        end else if (p_type > FT_LAST) begin
          p_phase = PH_SKIP;
        end else begin
          p_phase = phase_at(0);
        end
      end
    end else begin
      pos = p_pos;
      ok = 1'b1;
      case (p_phase)
        PH_PADLEN: begin
          p_pad = b;
          if (int'(b) > int'(p_len) - fixed_len()) begin
            push_event(EV_SIZE_ERR, 0, 0, 0, 0, 0, 0);
            ok = 1'b0;
          end
        end
        PH_PRIO: begin
          p_acc = {p_acc[55:0], b};
          if (pos - int'(has_pad_field()) == 4)
            push_event(EV_PRIORITY, 0, p_acc[38:8], p_acc[39], p_acc[7:0], 0, 0);
        end
        PH_BODY: payload_event(b, pos - prefix_len());
        PH_ERRSKIP: ok = 1'b0;
        default: ;
      endcase
      if (pos + 1 >= int'(p_len)) begin
        if (ok) push_event(EV_END, 0, 0, 0, 0, 0, 0);
        p_phase = PH_HEADER;
        p_pos = 0;
      end else begin
        p_pos = pos + 1;
        if (!ok) p_phase = PH_ERRSKIP;
        else if (p_phase != PH_SKIP) p_phase = phase_at(pos + 1);
      end
    end
    if (step_count > 0) event_queue[$].last = 1'b1;
  endtask

  // Append one byte to the pending stream
  task automatic append_byte(logic [7:0] b);
    byte_queue = {byte_queue, b};
  endtask

  // Stimulus building
  task automatic add_frame(int len, logic [7:0] ftype, logic [7:0] flags,
                           logic [31:0] sid, logic [7:0] body[$]);
    append_byte(len[23:16]);
    append_byte(len[15:8]);
    append_byte(len[7:0]);
    append_byte(ftype);
    append_byte(flags);
    append_byte(sid[31:24]);
    append_byte(sid[23:16]);
    append_byte(sid[15:8]);
    append_byte(sid[7:0]);
    foreach (body[i]) append_byte(body[i]);
  endtask

  // Mostly well-formed frames of any type with random content
  task automatic add_random_frame();
    logic [7:0] body[$];
    logic [7:0] ftype;
    logic [7:0] flags;
    int         len;
    int         fixed;
    int         pad;
    int         pick;
    pick = $urandom_range(0, 99);
    ftype = (pick < 90) ? 8'($urandom_range(0, 9)) : 8'($urandom_range(10, 255));
    flags = 8'($urandom);
    fixed = 0;
    if (flags[FLAG_PADDED_BIT] && (ftype <= FT_HEADERS || ftype == FT_PUSH)) fixed = 1;
    if (ftype == FT_HEADERS && flags[FLAG_PRIO_BIT]) fixed += 5;
    case (ftype)
      FT_PRIORITY: len = 5;
      FT_RST, FT_WINDOW: len = 4;
      FT_PING: len = 8;
      FT_SETTINGS: len = flags[FLAG_ACK_BIT] ? 0 : 6 * $urandom_range(0, 3);
      FT_PUSH: len = fixed + 4 + $urandom_range(0, 6);
      FT_GOAWAY: len = 8 + $urandom_range(0, 6);
      default: len = fixed + $urandom_range(0, 8);
    endcase
    // Occasional broken length
    if ($urandom_range(0, 99) < 12) len = $urandom_range(0, 12);
    pad = (len > fixed) ? $urandom_range(0, len - fixed) : 0;
    if ($urandom_range(0, 9) == 0) pad = $urandom;
    for (int i = 0; i < len; i++) begin
      if (i == 0 && fixed > 0 && flags[FLAG_PADDED_BIT]) body = {body, 8'(pad)};
      else body = {body, 8'($urandom)};
    end
    add_frame(len, ftype, flags, $urandom, body);
  endtask

  // Directed frames, then random
  initial begin
    logic [7:0] body[$];
    errors = 0;
    p_phase = PH_HEADER; p_pos = 0; p_type = 0; p_flags = 0; p_sid = 0;
    p_len = 0; p_pad = 0; p_acc = 0; p_setid = 0;
    body = '{8'h00, 8'hFF};
    add_frame(2, FT_DATA, 8'h00, 32'hFFFF_FFFF, body);
    body = '{8'h01, 8'hAA, 8'h55};
    add_frame(3, FT_DATA, 8'h08, 32'h1, body);
    body = '{8'h09, 8'h00};
    add_frame(2, FT_DATA, 8'h08, 32'h3, body);
    body = '{8'h80, 8'h00, 8'h00, 8'h01, 8'hFF, 8'h7E};
    add_frame(6, FT_HEADERS, 8'h20, 32'h5, body);
    body = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
    add_frame(5, FT_PRIORITY, 8'h00, 32'h7, body);
    body = '{8'h00, 8'h00};
    add_frame(2, FT_PRIORITY, 8'h00, 32'h7, body);
    body = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
    add_frame(4, FT_RST, 8'h00, 32'h9, body);
    body = '{8'h00, 8'h04, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    add_frame(6, FT_SETTINGS, 8'h00, 32'h0, body);
    body = {};
    add_frame(0, FT_SETTINGS, 8'h01, 32'h0, body);
    body = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    add_frame(6, FT_SETTINGS, 8'h01, 32'h0, body);
    body = '{8'h00, 8'h0C, 8'h80, 8'h00, 8'h00, 8'h02, 8'h41};
    add_frame(7, FT_PUSH, 8'h08, 32'h1, body);
    body = '{8'hFF, 8'hFE, 8'hFD, 8'hFC, 8'hFB, 8'hFA, 8'hF9, 8'hF8};
    add_frame(8, FT_PING, 8'h01, 32'h0, body);
    body = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h02, 8'h7A};
    add_frame(9, FT_GOAWAY, 8'h00, 32'h0, body);
    body = '{8'h80, 8'h00, 8'h10, 8'h00};
    add_frame(4, FT_WINDOW, 8'h00, 32'h1, body);
    body = '{8'h11, 8'h22};
    add_frame(2, 8'hFF, 8'hFF, 32'h8000_0001, body);
    body = '{8'h33};
    add_frame(1, FT_LAST, 8'h00, 32'h1, body);
    while (byte_queue.size() < 1500) add_random_frame();
  end

  // Driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      data_byte <= 8'h00;
    end else begin
      if (in_valid && !in_stall) begin
        predict_byte(data_byte);
        void'(byte_queue.pop_front());
      end
      if (in_valid && in_stall) begin
        // hold beat
      end else if (byte_queue.size() > (in_valid && !in_stall ? 0 : 0) &&
                   (quiet_in || $urandom_range(0, 99) >= 15)) begin
        in_valid <= 1'b1;
        data_byte <= byte_queue[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    frame_event_t e;
    frame_event_t got;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{event_res, frame_type, frame_flags, frame_stream, payload_length,
                content_byte, dependency_stream, exclusive_bit, priority_weight,
                setting_identifier, word_value, last_of_step};
        if (event_queue.size() == 0) begin
          $display("%0t: unexpected event beat, actual %p", $realtime, got);
          errors++;
        end else begin
          e = event_queue.pop_front();
          if (got !== e) begin
            $display("%0t: event mismatch, expected %p, actual %p", $realtime, e, got);
            errors++;
          end
        end
      end
      out_stall <= !quiet_out && ($urandom_range(0, 99) < 15);
    end
  end

  // Reset, quiet stretch and end of run
  initial begin
    int wait_cycles;
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = 8'h00;
    out_stall = 1'b0;
    quiet_in = 1'b0;
    quiet_out = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    repeat (600) @(posedge clk);
    quiet_in <= 1'b1;
    quiet_out <= 1'b1;
    repeat (400) @(posedge clk);
    quiet_in <= 1'b0;
    quiet_out <= 1'b0;
    wait (byte_queue.size() == 0);
    wait_cycles = 0;
    while (event_queue.size() != 0 && wait_cycles < 10000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (10) @(posedge clk);
    if (errors == 0 && event_queue.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      if (event_queue.size() != 0)
        $display("%0t: %0d expected events never arrived", $realtime, event_queue.size());
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
